// ===== rtl/core/c_source_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// c source tokenizer assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef C_SOURCE_TOKENIZER_TOP_MACROS_SVH
`define C_SOURCE_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTH

// plain property check under clock and active-low reset
`define CST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cst assertion failed");

// antecedent in one cycle implies consequent in the next
`define CST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cst assertion failed");

`else

`define CST_ASSERT(lbl, clk, rstn, prop)
`define CST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// shared types and constants of the c source tokenizer
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int ByteWidth = 8;
  localparam int KindWidth = 4;
  localparam int OffsWidth = 24;
  localparam int StateWidth = 4;

  // lexer state codes
  localparam logic [StateWidth-1:0] StIdle     = 4'd0;
  localparam logic [StateWidth-1:0] StName     = 4'd1;
  localparam logic [StateWidth-1:0] StNum      = 4'd2;
  localparam logic [StateWidth-1:0] StOp       = 4'd3;
  localparam logic [StateWidth-1:0] StString   = 4'd4;
  localparam logic [StateWidth-1:0] StLcomment = 4'd5;
  localparam logic [StateWidth-1:0] StBcomment = 4'd6;
  localparam logic [StateWidth-1:0] StDouble   = 4'd7;
  localparam logic [StateWidth-1:0] StFloat    = 4'd8;
  localparam logic [StateWidth-1:0] StHex      = 4'd9;
  localparam logic [StateWidth-1:0] StDot      = 4'd10;
  localparam logic [StateWidth-1:0] StChars    = 4'd11;

  // token kind codes
  localparam logic [KindWidth-1:0] KindName     = 4'd0;
  localparam logic [KindWidth-1:0] KindInt      = 4'd1;
  localparam logic [KindWidth-1:0] KindDouble   = 4'd2;
  localparam logic [KindWidth-1:0] KindFloat    = 4'd3;
  localparam logic [KindWidth-1:0] KindHex      = 4'd4;
  localparam logic [KindWidth-1:0] KindOp       = 4'd5;
  localparam logic [KindWidth-1:0] KindString   = 4'd6;
  localparam logic [KindWidth-1:0] KindChar     = 4'd7;
  localparam logic [KindWidth-1:0] KindLcomment = 4'd8;
  localparam logic [KindWidth-1:0] KindBcomment = 4'd9;

  // characters
  localparam logic [ByteWidth-1:0] ChrNul       = 8'h00;
  localparam logic [ByteWidth-1:0] ChrBackslash = 8'd92;
  localparam logic [ByteWidth-1:0] ChrNewline   = 8'h0A;
  localparam logic [ByteWidth-1:0] ChrZero      = 8'h30;
  localparam logic [ByteWidth-1:0] ChrX         = 8'h78;
  localparam logic [ByteWidth-1:0] ChrF         = 8'h66;
  localparam logic [ByteWidth-1:0] ChrDot       = 8'h2E;
  localparam logic [ByteWidth-1:0] ChrStar      = 8'h2A;
  localparam logic [ByteWidth-1:0] ChrSlash     = 8'h2F;
  localparam logic [ByteWidth-1:0] ChrQuote     = 8'h27;
  localparam logic [ByteWidth-1:0] ChrDquote    = 8'h22;

  // character classes of one byte
  typedef struct packed {
    logic is_digit;
    logic is_alpha;
    logic is_hex;
    logic is_op;
    logic is_dot;
    logic is_quote;
    logic is_dquote;
    logic is_newline;
    logic is_star;
    logic is_slash;
    logic is_f;
    logic is_x;
    logic is_nul;
  } char_class_t;

  // one token result
  typedef struct packed {
    logic                 valid;
    logic [KindWidth-1:0] token_kind;
    logic [OffsWidth-1:0] token_start;
    logic [OffsWidth-1:0] token_end;
  } token_res_t;

  typedef struct packed {
    logic                 valid;
    logic [KindWidth-1:0] kind;
  } kind_map_t;

  // kind reported for the state a token was in
  function automatic kind_map_t state_kind(input logic [StateWidth-1:0] st);
    kind_map_t km;
    km.valid = 1'b1;
    km.kind  = KindName;
    case (st)
      StName:     km.kind = KindName;
      StNum:      km.kind = KindInt;
      StDouble:   km.kind = KindDouble;
      StFloat:    km.kind = KindFloat;
      StHex:      km.kind = KindHex;
      StOp:       km.kind = KindOp;
      StString:   km.kind = KindString;
      StChars:    km.kind = KindChar;
      StLcomment: km.kind = KindLcomment;
      StBcomment: km.kind = KindBcomment;
      default:    km.valid = 1'b0;
    endcase
    return km;
  endfunction

endpackage

// ===== rtl/core/cst_byte_if.sv =====
// ----------------------------------------------------------------------------
// cst_byte_if
// valid/ready channel carrying one source byte per transaction
// ----------------------------------------------------------------------------
interface cst_byte_if;
  logic                           valid;
  logic                           ready;
  logic [cst_pkg::ByteWidth-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ===== rtl/core/cst_token_if.sv =====
// ----------------------------------------------------------------------------
// cst_token_if
// valid/ready channel carrying one token descriptor per transaction
// ----------------------------------------------------------------------------
interface cst_token_if;
  logic                           valid;
  logic                           ready;
  logic [cst_pkg::KindWidth-1:0]  token_kind;
  logic [cst_pkg::OffsWidth-1:0]  token_start;
  logic [cst_pkg::OffsWidth-1:0]  token_end;

  modport source (output valid, output token_kind, output token_start, output token_end,
                  input ready);
  modport sink (input valid, input token_kind, input token_start, input token_end,
                output ready);
endinterface

// ===== rtl/core/cst_char_class.sv =====
// ----------------------------------------------------------------------------
// cst_char_class
// decodes one byte into its lexical character classes
// ----------------------------------------------------------------------------
module cst_char_class (
  input  logic [cst_pkg::ByteWidth-1:0] char_i,
  output cst_pkg::char_class_t          class_o
);

  logic op_hit;

  always_comb begin
    op_hit = 1'b0;
    case (char_i) inside
      "=", "+", "-", "*", "/", ",", "?", "!", "&", "|", "~",
      "^", "<", ">", ":", ";", "[", "]", "{", "}", "(", ")": op_hit = 1'b1;
      default: op_hit = 1'b0;
    endcase
  end

  always_comb begin
    class_o.is_digit   = (char_i >= "0") && (char_i <= "9");
    class_o.is_alpha   = ((char_i >= "A") && (char_i <= "Z")) ||
                         ((char_i >= "a") && (char_i <= "z")) || (char_i == "_");
    class_o.is_hex     = class_o.is_digit || ((char_i >= "A") && (char_i <= "F")) ||
                         ((char_i >= "a") && (char_i <= "f"));
    class_o.is_op      = op_hit;
    class_o.is_dot     = (char_i == cst_pkg::ChrDot);
    class_o.is_quote   = (char_i == cst_pkg::ChrQuote);
    class_o.is_dquote  = (char_i == cst_pkg::ChrDquote);
    class_o.is_newline = (char_i == cst_pkg::ChrNewline);
    class_o.is_star    = (char_i == cst_pkg::ChrStar);
    class_o.is_slash   = (char_i == cst_pkg::ChrSlash);
    class_o.is_f       = (char_i == cst_pkg::ChrF);
    class_o.is_x       = (char_i == cst_pkg::ChrX);
    class_o.is_nul     = (char_i == cst_pkg::ChrNul);
  end

endmodule

// ===== rtl/core/cst_step.sv =====
// ----------------------------------------------------------------------------
// cst_step
// next lexer state and token result for one byte
// ----------------------------------------------------------------------------
module cst_step #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic [cst_pkg::ByteWidth-1:0]  char_i,
  input  cst_pkg::char_class_t           class_i,
  input  logic [cst_pkg::StateWidth-1:0] state_i,
  input  logic [cst_pkg::ByteWidth-1:0]  prev_i,
  input  logic [POSITION_WIDTH-1:0]      start_i,
  input  logic [POSITION_WIDTH-1:0]      end_i,
  input  logic [POSITION_WIDTH-1:0]      pos_i,
  output logic [cst_pkg::StateWidth-1:0] state_o,
  output logic [cst_pkg::ByteWidth-1:0]  prev_o,
  output logic [POSITION_WIDTH-1:0]      start_o,
  output logic [POSITION_WIDTH-1:0]      end_o,
  output logic [POSITION_WIDTH-1:0]      pos_o,
  output cst_pkg::token_res_t            res_o
);

  logic [cst_pkg::StateWidth-1:0]   st_n;
  logic [POSITION_WIDTH-1:0]        start_n;
  logic [POSITION_WIDTH-1:0]        end_n;
  logic [POSITION_WIDTH-1:0]        pos_inc;
  logic [POSITION_WIDTH-1:0]        diff;
  logic                             close;
  logic [POSITION_WIDTH+23:0]       start_ext;
  logic [POSITION_WIDTH+23:0]       end_ext;
  cst_pkg::kind_map_t               km;

  assign pos_inc = pos_i + 1'b1;

  always_comb begin
    st_n    = state_i;
    start_n = start_i;
    end_n   = end_i;
    close   = 1'b0;

    unique case (state_i)
      cst_pkg::StIdle: begin
        if (class_i.is_quote) begin
          st_n = cst_pkg::StChars;  start_n = pos_inc;
        end else if (class_i.is_dquote) begin
          st_n = cst_pkg::StString; start_n = pos_inc;
        end else if (class_i.is_digit) begin
          st_n = cst_pkg::StNum;    start_n = pos_i;
        end else if (class_i.is_alpha) begin
          st_n = cst_pkg::StName;   start_n = pos_i;
        end else if (class_i.is_op) begin
          st_n = cst_pkg::StOp;     start_n = pos_i;
        end else if (class_i.is_dot) begin
          st_n = cst_pkg::StDot;    start_n = pos_i;
        end
      end
      cst_pkg::StName: begin
        if (!(class_i.is_alpha || class_i.is_digit)) close = 1'b1;
      end
      cst_pkg::StNum: begin
        if (class_i.is_digit) begin
          st_n = cst_pkg::StNum;
        end else if (class_i.is_dot) begin
          st_n = cst_pkg::StDouble;
        end else if (class_i.is_f) begin
          st_n = cst_pkg::StFloat;
        end else if (class_i.is_x && (prev_i == cst_pkg::ChrZero)) begin
          st_n = cst_pkg::StHex;
        end else begin
          close = 1'b1;
        end
      end
      cst_pkg::StDouble: begin
        if (class_i.is_digit) begin
          st_n = cst_pkg::StDouble;
        end else if (class_i.is_f) begin
          st_n = cst_pkg::StFloat;
        end else begin
          close = 1'b1;
        end
      end
      cst_pkg::StFloat: begin
        close = 1'b1;
      end
      cst_pkg::StHex: begin
        if (!class_i.is_hex) close = 1'b1;
      end
      cst_pkg::StDot: begin
        st_n = class_i.is_digit ? cst_pkg::StNum : cst_pkg::StOp;
      end
      cst_pkg::StOp: begin
        if (class_i.is_star && (prev_i == cst_pkg::ChrSlash)) begin
          st_n = cst_pkg::StBcomment; start_n = pos_inc;
        end else if (class_i.is_slash && (prev_i == cst_pkg::ChrSlash)) begin
          st_n = cst_pkg::StLcomment; start_n = pos_inc;
        end else if (!(class_i.is_op || class_i.is_dot)) begin
          close = 1'b1;
        end
      end
      cst_pkg::StString: begin
        if (class_i.is_dquote) begin
          st_n = cst_pkg::StIdle; end_n = pos_i;
        end
      end
      cst_pkg::StChars: begin
        if (class_i.is_quote && (prev_i != cst_pkg::ChrBackslash)) begin
          st_n = cst_pkg::StIdle; end_n = pos_i;
        end
      end
      cst_pkg::StLcomment: begin
        if (class_i.is_newline) begin
          st_n = cst_pkg::StIdle; end_n = pos_i;
        end
      end
      cst_pkg::StBcomment: begin
        if (class_i.is_slash && (prev_i == cst_pkg::ChrStar)) begin
          st_n = cst_pkg::StIdle; end_n = pos_i - 1'b1;
        end
      end
      default: st_n = cst_pkg::StIdle;
    endcase

    if (close) begin
      st_n  = cst_pkg::StIdle;
      end_n = pos_i;
    end
  end

  // token report, taken before the delimiter is classified again
  assign diff      = end_n - start_n;
  assign km        = cst_pkg::state_kind(state_i);
  assign start_ext = {24'b0, start_n};
  assign end_ext   = {24'b0, end_n};

  always_comb begin
    res_o.valid       = (st_n != state_i) && (diff != '0) && !diff[POSITION_WIDTH-1] &&
                        km.valid;
    res_o.token_kind  = km.kind;
    res_o.token_start = start_ext[23:0];
    res_o.token_end   = end_ext[23:0];
  end

  always_comb begin
    state_o = st_n;
    start_o = start_n;
    end_o   = end_n;
    prev_o  = char_i;
    pos_o   = pos_inc;

    // delimiter starts the next token from idle
    if (close && !class_i.is_nul) begin
      if (class_i.is_quote) begin
        state_o = cst_pkg::StChars;  start_o = pos_inc;
      end else if (class_i.is_dquote) begin
        state_o = cst_pkg::StString; start_o = pos_inc;
      end else if (class_i.is_digit) begin
        state_o = cst_pkg::StNum;    start_o = pos_i;
      end else if (class_i.is_alpha) begin
        state_o = cst_pkg::StName;   start_o = pos_i;
      end else if (class_i.is_op) begin
        state_o = cst_pkg::StOp;     start_o = pos_i;
      end else if (class_i.is_dot) begin
        state_o = cst_pkg::StDot;    start_o = pos_i;
      end
    end

    // end of text clears state and position
    if (class_i.is_nul) begin
      state_o = cst_pkg::StIdle;
      start_o = '0;
      end_o   = '0;
      prev_o  = cst_pkg::ChrNul;
      pos_o   = '0;
    end
  end

endmodule

// ===== rtl/core/c_source_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// c_source_tokenizer_top
// streaming lexer for c source text, one byte in, zero or one token out
//
// usage:
//   byte_i carries one source byte per transaction; byte 0 ends the text,
//   closes any open name, number or operator run and clears the lexer state
//   and the byte position. token_o carries kind, start and end offset of
//   each finished token (end is one past the last byte of the token).
//   path: an accepted byte waits in the input register, is lexed from there
//   into the result register, and its token, if any, is offered from that register.
//   throughput: one byte per cycle while token_o does not stall, set by the
//   combinational lexer step between the input register and the result register.
//   stall: while a token waits on token_o, the lexer holds; one more byte
//   is still taken into the input register, after which ready drops.
//   reset: lexer idle, offsets and position zero, both registers empty.
// ----------------------------------------------------------------------------
`include "c_source_tokenizer_top_macros.svh"

module c_source_tokenizer_top #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cst_byte_if.sink           byte_i,
  cst_token_if.source        token_o
);

  // input register
  logic                            in_valid_q;
  logic [cst_pkg::ByteWidth-1:0]   in_byte_q;

  // lexer state
  logic [cst_pkg::StateWidth-1:0]  state_q, state_d;
  logic [cst_pkg::ByteWidth-1:0]   prev_q, prev_d;
  logic [POSITION_WIDTH-1:0]       start_q, start_d;
  logic [POSITION_WIDTH-1:0]       end_q, end_d;
  logic [POSITION_WIDTH-1:0]       pos_q, pos_d;

  // result register
  logic                            out_valid_q;
  cst_pkg::token_res_t             out_res_q;

  cst_pkg::char_class_t            char_class;
  cst_pkg::token_res_t             step_res;
  logic                            out_free;
  logic                            step_fire;

  // result slot can take a new value when empty or being drained
  assign out_free  = !out_valid_q || token_o.ready;
  assign step_fire = in_valid_q && out_free;
  assign byte_i.ready = !in_valid_q || out_free;

  cst_char_class u_class (
    .char_i  (in_byte_q),
    .class_o (char_class)
  );

  cst_step #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_step (
    .char_i  (in_byte_q),
    .class_i (char_class),
    .state_i (state_q),
    .prev_i  (prev_q),
    .start_i (start_q),
    .end_i   (end_q),
    .pos_i   (pos_q),
    .state_o (state_d),
    .prev_o  (prev_d),
    .start_o (start_d),
    .end_o   (end_d),
    .pos_o   (pos_d),
    .res_o   (step_res)
  );

  // input register, refilled whenever the byte in it moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.text_byte;
    end
  end

  // lexer state advances once per lexed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cst_pkg::StIdle;
      prev_q  <= cst_pkg::ChrNul;
      start_q <= '0;
      end_q   <= '0;
      pos_q   <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
      prev_q  <= prev_d;
      start_q <= start_d;
      end_q   <= end_d;
      pos_q   <= pos_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_fire && step_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && step_res.valid) begin
      out_res_q <= step_res;
    end
  end

  assign token_o.valid       = out_valid_q;
  assign token_o.token_kind  = out_res_q.token_kind;
  assign token_o.token_start = out_res_q.token_start;
  assign token_o.token_end   = out_res_q.token_end;

  // end of text leaves the lexer idle at position zero
  `CST_ASSERT_NEXT(a_nul_clears, clk_i, rst_ni, step_fire && char_class.is_nul, state_q == cst_pkg::StIdle && pos_q == '0)
  // position moves by one for every other lexed byte
  `CST_ASSERT_NEXT(a_pos_step, clk_i, rst_ni, step_fire && !char_class.is_nul, pos_q == POSITION_WIDTH'($past(pos_q) + 1'b1))
  // a new token only appears right after a lexer step
  `CST_ASSERT(a_res_from_step, clk_i, rst_ni, $rose(out_valid_q) |-> $past(step_fire))
  // a byte waiting on a blocked result is not lost
  `CST_ASSERT_NEXT(a_in_held, clk_i, rst_ni, in_valid_q && !out_free, in_valid_q && $stable(in_byte_q))

endmodule

// ===== tb/c_source_tokenizer_top_test.sv =====
// ----------------------------------------------------------------------------
// c_source_tokenizer_top_test
// streams directed and random c source text into the tokenizer, predicts
// every token from its own lexer state machine, and compares each token
// transaction on token_o field by field with the oldest predicted token
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_source_tokenizer_top_test;

  localparam int CycleLimit = 200000;
  localparam int TextItems  = 1650;
  localparam int DrainWait  = 8;
  localparam int IdlePct    = 34;

  // character sets for the text generator
  localparam string AlphaSet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  localparam string DigitSet = "0123456789";
  localparam string HexSet   = "0123456789abcdefABCDEF";
  localparam string OpSet    = "=+-*/,?!&|~^<>:;[]{}()";
  localparam string GapSet   = " \t\n";

  typedef struct packed {
    logic [cst_pkg::KindWidth-1:0] kind;
    logic [cst_pkg::OffsWidth-1:0] first;
    logic [cst_pkg::OffsWidth-1:0] stop;
  } token_t;

  logic clk_i;
  logic rst_ni;

  cst_byte_if  byte_if ();
  cst_token_if token_if ();

  c_source_tokenizer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .token_o(token_if)
  );

  // text waiting to be driven, tokens predicted but not yet seen
  logic [cst_pkg::ByteWidth-1:0] source_text[$];
  token_t                        pending_tokens[$];

  // predicted lexer state
  logic [cst_pkg::StateWidth-1:0] lex_st;
  logic [cst_pkg::ByteWidth-1:0]  prev_chr;
  logic [cst_pkg::OffsWidth-1:0]  tok_start;
  logic [cst_pkg::OffsWidth-1:0]  tok_end;
  logic [cst_pkg::OffsWidth-1:0]  byte_pos;

  int unsigned accepted   = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  logic        byte_fire  = 1'b0;
  logic        live       = 1'b0;
  logic        calm;
  logic        nxt_valid;
  logic [cst_pkg::ByteWidth-1:0] nxt_byte;

  // --------------------------------------------------------------------------
  // character classes
  // --------------------------------------------------------------------------
  function automatic logic is_digit(input logic [cst_pkg::ByteWidth-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [cst_pkg::ByteWidth-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_hexd(input logic [cst_pkg::ByteWidth-1:0] c);
    return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic is_op(input logic [cst_pkg::ByteWidth-1:0] c);
    for (int i = 0; i < OpSet.len(); i++) begin
      if (c == OpSet[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // {reportable, kind} for the state a token was held in
  function automatic logic [cst_pkg::KindWidth:0] kind_for(
    input logic [cst_pkg::StateWidth-1:0] st
  );
    case (st)
      cst_pkg::StName:     return {1'b1, cst_pkg::KindName};
      cst_pkg::StNum:      return {1'b1, cst_pkg::KindInt};
      cst_pkg::StDouble:   return {1'b1, cst_pkg::KindDouble};
      cst_pkg::StFloat:    return {1'b1, cst_pkg::KindFloat};
      cst_pkg::StHex:      return {1'b1, cst_pkg::KindHex};
      cst_pkg::StOp:       return {1'b1, cst_pkg::KindOp};
      cst_pkg::StString:   return {1'b1, cst_pkg::KindString};
      cst_pkg::StChars:    return {1'b1, cst_pkg::KindChar};
      cst_pkg::StLcomment: return {1'b1, cst_pkg::KindLcomment};
      cst_pkg::StBcomment: return {1'b1, cst_pkg::KindBcomment};
      default:             return '0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // lexer prediction
  // --------------------------------------------------------------------------
  task automatic clear_lexer();
    lex_st    = cst_pkg::StIdle;
    prev_chr  = cst_pkg::ChrNul;
    tok_start = '0;
    tok_end   = '0;
    byte_pos  = '0;
  endtask

  // open a token from idle; quotes start one past the opening quote
  task automatic start_token(input logic [cst_pkg::ByteWidth-1:0] c);
    if (c == cst_pkg::ChrQuote) begin
      lex_st = cst_pkg::StChars;
      tok_start = byte_pos + 1'b1;
    end else if (c == cst_pkg::ChrDquote) begin
      lex_st = cst_pkg::StString;
      tok_start = byte_pos + 1'b1;
    end else if (is_digit(c)) begin
      lex_st = cst_pkg::StNum;
      tok_start = byte_pos;
    end else if (is_alpha(c)) begin
      lex_st = cst_pkg::StName;
      tok_start = byte_pos;
    end else if (is_op(c)) begin
      lex_st = cst_pkg::StOp;
      tok_start = byte_pos;
    end else if (c == cst_pkg::ChrDot) begin
      lex_st = cst_pkg::StDot;
      tok_start = byte_pos;
    end
  endtask

  task automatic lex_step(input logic [cst_pkg::ByteWidth-1:0] c);
    logic [cst_pkg::StateWidth-1:0] was;
    logic [cst_pkg::OffsWidth-1:0]  span;
    logic [cst_pkg::KindWidth:0]    km;
    logic                           close;
    token_t                         tk;
    was   = lex_st;
    close = 1'b0;
    case (was)
      cst_pkg::StIdle: start_token(c);
      cst_pkg::StName: if (!(is_alpha(c) || is_digit(c))) close = 1'b1;
      cst_pkg::StNum: begin
        if (is_digit(c)) begin
        end else if (c == cst_pkg::ChrDot) begin
          lex_st = cst_pkg::StDouble;
        end else if (c == cst_pkg::ChrF) begin
          lex_st = cst_pkg::StFloat;
        end else if (c == cst_pkg::ChrX && prev_chr == cst_pkg::ChrZero) begin
          lex_st = cst_pkg::StHex;
        end else begin
          close = 1'b1;
        end
      end
      cst_pkg::StDouble: begin
        if (is_digit(c)) begin
        end else if (c == cst_pkg::ChrF) begin
          lex_st = cst_pkg::StFloat;
        end else begin
          close = 1'b1;
        end
      end
      cst_pkg::StFloat: close = 1'b1;
      cst_pkg::StHex: if (!is_hexd(c)) close = 1'b1;
      // the byte after a leading dot is swallowed without classification
      cst_pkg::StDot: lex_st = is_digit(c) ? cst_pkg::StNum : cst_pkg::StOp;
      cst_pkg::StOp: begin
        if (c == cst_pkg::ChrStar && prev_chr == cst_pkg::ChrSlash) begin
          lex_st = cst_pkg::StBcomment;
          tok_start = byte_pos + 1'b1;
        end else if ((c == cst_pkg::ChrStar || c == cst_pkg::ChrSlash) &&
                     prev_chr == cst_pkg::ChrSlash) begin
          lex_st = cst_pkg::StLcomment;
          tok_start = byte_pos + 1'b1;
        end else if (!(is_op(c) || c == cst_pkg::ChrDot)) begin
          close = 1'b1;
        end
      end
      cst_pkg::StString: begin
        if (c == cst_pkg::ChrDquote) begin
          lex_st = cst_pkg::StIdle;
          tok_end = byte_pos;
        end
      end
      cst_pkg::StChars: begin
        if (c == cst_pkg::ChrQuote && prev_chr != cst_pkg::ChrBackslash) begin
          lex_st = cst_pkg::StIdle;
          tok_end = byte_pos;
        end
      end
      cst_pkg::StLcomment: begin
        if (c == cst_pkg::ChrNewline) begin
          lex_st = cst_pkg::StIdle;
          tok_end = byte_pos;
        end
      end
      cst_pkg::StBcomment: begin
        // the closing star is left out of the comment body
        if (c == cst_pkg::ChrSlash && prev_chr == cst_pkg::ChrStar) begin
          lex_st = cst_pkg::StIdle;
          tok_end = byte_pos - 1'b1;
        end
      end
      default: lex_st = cst_pkg::StIdle;
    endcase

    if (close) begin
      lex_st = cst_pkg::StIdle;
      tok_end = byte_pos;
    end

    // report on any state change out of a reportable state with a short positive span
    if (lex_st != was) begin
      span = tok_end - tok_start;
      km = kind_for(was);
      if (span != '0 && !span[cst_pkg::OffsWidth-1] && km[cst_pkg::KindWidth]) begin
        tk.kind  = km[cst_pkg::KindWidth-1:0];
        tk.first = tok_start;
        tk.stop  = tok_end;
        pending_tokens.push_back(tk);
      end
    end

    // the delimiter opens the next token, unless it ends the text
    if (close && c != cst_pkg::ChrNul) start_token(c);

    if (c == cst_pkg::ChrNul) begin
      clear_lexer();
    end else begin
      prev_chr = c;
      byte_pos = byte_pos + 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // text generator
  // --------------------------------------------------------------------------
  function automatic logic [cst_pkg::ByteWidth-1:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
  endtask

  // any nonzero byte other than the given terminator
  function automatic logic [cst_pkg::ByteWidth-1:0] body_chr(
    input logic [cst_pkg::ByteWidth-1:0] stop_chr
  );
    logic [cst_pkg::ByteWidth-1:0] b;
    do b = cst_pkg::ByteWidth'($urandom_range(1, 255)); while (b == stop_chr);
    return b;
  endfunction

  // one well-formed token, gap or noise byte with random content, sometimes cut off by end of text
  task automatic add_token();
    int unsigned sel;
    int unsigned n;
    logic        cut;
    cut     = ($urandom_range(99) < 3);
    sel     = $urandom_range(99);
    n       = $urandom_range(0, 5);
    if (sel < 14) begin
      source_text.push_back(pick(AlphaSet));
      repeat (n) source_text.push_back($urandom_range(1) ? pick(AlphaSet) : pick(DigitSet));
    end else if (sel < 24) begin
      repeat (n + 1) source_text.push_back(pick(DigitSet));
    end else if (sel < 32) begin
      repeat ($urandom_range(1, 3)) source_text.push_back(pick(DigitSet));
      source_text.push_back(cst_pkg::ChrDot);
      repeat (n) source_text.push_back(pick(DigitSet));
      if ($urandom_range(1)) source_text.push_back(cst_pkg::ChrF);
    end else if (sel < 38) begin
      source_text.push_back(cst_pkg::ChrZero);
      source_text.push_back(cst_pkg::ChrX);
      repeat (n + 1) source_text.push_back(pick(HexSet));
    end else if (sel < 42) begin
      source_text.push_back(cst_pkg::ChrDot);
      source_text.push_back($urandom_range(3) == 0 ? pick(OpSet) : pick(DigitSet));
      repeat (n) source_text.push_back(pick(DigitSet));
    end else if (sel < 56) begin
      repeat ($urandom_range(1, 3)) source_text.push_back(pick(OpSet));
    end else if (sel < 64) begin
      source_text.push_back(cst_pkg::ChrDquote);
      repeat (n) source_text.push_back(body_chr(cst_pkg::ChrDquote));
      if (!cut) source_text.push_back(cst_pkg::ChrDquote);
    end else if (sel < 71) begin
      source_text.push_back(cst_pkg::ChrQuote);
      if ($urandom_range(2) == 0) begin
        source_text.push_back(cst_pkg::ChrBackslash);
        source_text.push_back(body_chr(cst_pkg::ChrNul));
      end else begin
        source_text.push_back(body_chr(cst_pkg::ChrQuote));
      end
      if (!cut) source_text.push_back(cst_pkg::ChrQuote);
    end else if (sel < 77) begin
      push_text("//");
      repeat (n) source_text.push_back(body_chr(cst_pkg::ChrNewline));
      if (!cut) source_text.push_back(cst_pkg::ChrNewline);
    end else if (sel < 83) begin
      push_text("/*");
      repeat (n) source_text.push_back(body_chr(cst_pkg::ChrSlash));
      if (!cut) push_text("*/");
    end else if (sel < 95) begin
      source_text.push_back(pick(GapSet));
    end else begin
      // noise: any nonzero byte
      source_text.push_back(cst_pkg::ByteWidth'($urandom_range(1, 255)));
    end
    if (cut || $urandom_range(99) < 2) source_text.push_back(cst_pkg::ChrNul);
  endtask

  // --------------------------------------------------------------------------
  // clock and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout, %0d tokens still expected", $time, pending_tokens.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on every accepted byte, check every accepted token
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    token_t exp;
    live      = rst_ni;
    byte_fire = rst_ni && byte_if.valid && byte_if.ready;
    if (byte_fire) begin
      lex_step(byte_if.text_byte);
      accepted++;
    end
    if (rst_ni && token_if.valid && token_if.ready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: token with none expected: actual kind %0d start %0d end %0d",
                 $time, token_if.token_kind, token_if.token_start, token_if.token_end);
        mismatches++;
      end else begin
        exp = pending_tokens.pop_front();
        if (token_if.token_kind !== exp.kind) begin
          $display("%0t: token_kind mismatch: expected %0d actual %0d",
                   $time, exp.kind, token_if.token_kind);
          mismatches++;
        end
        if (token_if.token_start !== exp.first) begin
          $display("%0t: token_start mismatch: expected %0d actual %0d",
                   $time, exp.first, token_if.token_start);
          mismatches++;
        end
        if (token_if.token_end !== exp.stop) begin
          $display("%0t: token_end mismatch: expected %0d actual %0d",
                   $time, exp.stop, token_if.token_end);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver and sink: both change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    // a quiet window with no idling on either side
    calm      = (accepted >= 700 && accepted < 1000);
    nxt_valid = byte_if.valid;
    nxt_byte  = byte_if.text_byte;
    if (live && (!byte_if.valid || byte_fire)) begin
      nxt_valid = 1'b0;
      if (source_text.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt_byte  = source_text.pop_front();
        nxt_valid = 1'b1;
      end
    end
    byte_if.valid     <= nxt_valid;
    byte_if.text_byte <= nxt_byte;
    token_if.ready    <= calm || ($urandom_range(99) >= IdlePct);
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    byte_if.valid     = 1'b0;
    byte_if.text_byte = '0;
    token_if.ready    = 1'b0;
    rst_ni            = 1'b0;
    clear_lexer();

    // directed: name closed by a leading dot that turns into an operator run,
    // hex prefix, unknown byte 255, double into float, dot then number,
    // escaped quote in a char, block comment, empty line comment,
    // unterminated string cut off by end of text
    push_text("x.+0x1F");
    source_text.push_back(8'hFF);
    push_text("1.5f.7'\\''/*c*/");
    push_text("//\n\"s");
    source_text.push_back(cst_pkg::ChrNul);

    // random: mostly well-formed tokens, some gaps, noise and cut-off text
    while (source_text.size() < TextItems) add_token();
    source_text.push_back(cst_pkg::ChrNul);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (source_text.size() != 0 || byte_if.valid || pending_tokens.size() != 0);
    // room for a token still in the input and result registers and any stray token
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cst_pkg.sv
rtl/core/cst_byte_if.sv
rtl/core/cst_token_if.sv
rtl/core/cst_char_class.sv
rtl/core/cst_step.sv
rtl/core/c_source_tokenizer_top.sv
tb/c_source_tokenizer_top_test.sv
